[sv/tlrr_pkg.sv]
// ----------------------------------------------------------------------------
// tlrr_pkg
// shared types, codes and sizes of the two-level round-robin task scheduler
// ----------------------------------------------------------------------------
package tlrr_pkg;

  // sizes
  localparam int MAX_TASKS_DEF = 16;  // default number of task slots
  localparam int SLOT_W        = 4;   // width of a slot number
  localparam int SLOT_CAP      = 16;  // slots reachable by a slot number
  localparam int CNT_W         = 5;   // width of the high-priority count
  localparam int CMD_W         = 3;
  localparam int STAT_W        = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_LOW  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_HIGH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUANTUM  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] task_id;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] running_id;
    logic              switched;
    logic [SLOT_W-1:0] new_id;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture an accepted command
    logic exec;       // apply the command to the slot table
    logic next;       // find the next present slot
    logic high_pick;  // run first high slot, else next present slot
    logic out_load;   // load the result register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // result register empty or being drained this cycle
  } dp_status_t;

endpackage

[sv/tlrr_ctrl.sv]
// ----------------------------------------------------------------------------
// tlrr_ctrl
// sequencer of the scheduler: steps one command through the datapath
// ----------------------------------------------------------------------------
module tlrr_ctrl
  import tlrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t dp_st,
  output ctl_t       ctl
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_NEXT = 5'b00100,
    S_HIGH = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   load;

  // a new command may enter while the previous result is handed over
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_OUT) && dp_st.out_free);
  assign load     = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.load     = load;
    case (state_r)
      S_IDLE: begin
        if (load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        ctl.next  = 1'b1;
        state_nxt = S_HIGH;
      end
      S_HIGH: begin
        ctl.high_pick = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (dp_st.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = load ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/tlrr_dp.sv]
// ----------------------------------------------------------------------------
// tlrr_dp
// slot table, running slot, ring searches and result register
// ----------------------------------------------------------------------------
module tlrr_dp
  import tlrr_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_t       ctl,
  output dp_status_t dp_st,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  localparam int NSLOT = (MAX_TASKS < SLOT_CAP) ? MAX_TASKS : SLOT_CAP;

  // lowest set bit of a slot vector
  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOT_CAP-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOT_CAP - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  logic [NSLOT-1:0]  present_r, high_r;
  logic [SLOT_W-1:0] running_r, before_r, from_r, pick_r, new_id_r;
  logic [CNT_W-1:0]  hc_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [SLOT_W-1:0] id_r;
  logic [STAT_W-1:0] status_r;
  logic              do_pick_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic [SLOT_CAP-1:0] pres_w, high_w, lim_w, free_w, id_oh, gt_w, ge_w;
  logic [SLOT_CAP-1:0] p_n, h_n;
  logic [CNT_W-1:0]    hc_n;
  logic [STAT_W-1:0]   st_n;
  logic [SLOT_W-1:0]   nid_n, from_n, free_id, next_id, high_id;
  logic                pick_req, run_clr, id_ok;

  assign pres_w  = SLOT_CAP'(present_r);
  assign high_w  = SLOT_CAP'(high_r);
  assign id_oh   = SLOT_CAP'(1) << id_r;
  assign id_ok   = pres_w[id_r];  // bits at and above NSLOT read as absent
  assign free_w  = ~pres_w & lim_w & ~SLOT_CAP'(1);
  assign free_id = first_set(free_w);

  always_comb begin
    for (int i = 0; i < SLOT_CAP; i++) begin
      lim_w[i] = (i < NSLOT);
      gt_w[i]  = (SLOT_W'(i) > from_r);
      ge_w[i]  = (SLOT_W'(i) >= pick_r);
    end
  end

  // next present slot after from_r, wrapping to the lowest one
  assign next_id = (|(pres_w & gt_w)) ? first_set(pres_w & gt_w) : first_set(pres_w);
  // first high slot from pick_r on, wrapping to the lowest one
  assign high_id = (|(high_w & ge_w)) ? first_set(high_w & ge_w) : first_set(high_w);

  // command effect on the slot table
  always_comb begin
    p_n      = pres_w;
    h_n      = high_w;
    hc_n     = hc_r;
    st_n     = ST_OK;
    nid_n    = '0;
    pick_req = 1'b0;
    run_clr  = 1'b0;
    from_n   = running_r;
    if (pres_w == '0) begin
      st_n = ST_EMPTY;
    end else begin
      case (cmd_r)
        CMD_CREATE: begin
          if (|free_w) begin
            p_n   = p_n | (SLOT_CAP'(1) << free_id);
            h_n   = h_n & ~(SLOT_CAP'(1) << free_id);
            nid_n = free_id;
          end else begin
            st_n = ST_FULL;
          end
        end
        CMD_REMOVE: begin
          if (!id_ok) begin
            st_n = ST_NOT_FOUND;
          end else begin
            if (high_w[id_r]) begin
              h_n  = h_n & ~id_oh;
              hc_n = hc_n - CNT_W'(1);
              // shell left as the only high task
              if ((id_r != '0) && (hc_n == CNT_W'(1)) && h_n[0]) begin
                h_n[0] = 1'b0;
                hc_n   = hc_n - CNT_W'(1);
              end
            end
            p_n = p_n & ~id_oh;
            h_n = h_n & ~id_oh;
            if (p_n == '0) begin
              run_clr = 1'b1;
              st_n    = ST_EMPTY;
            end else if (id_r == running_r) begin
              pick_req = 1'b1;
              from_n   = id_r;
            end
          end
        end
        CMD_SET_LOW: begin
          if ((id_r == '0) && (hc_r > CNT_W'(1))) begin
            st_n = ST_REFUSED;
          end else if (!id_ok) begin
            st_n = ST_NOT_FOUND;
          end else begin
            if (high_w[id_r]) begin
              h_n  = h_n & ~id_oh;
              hc_n = hc_n - CNT_W'(1);
            end
            if ((id_r != '0) && (hc_n == CNT_W'(1)) && h_n[0]) begin
              h_n[0] = 1'b0;
              hc_n   = hc_n - CNT_W'(1);
            end
          end
        end
        CMD_SET_HIGH: begin
          if (!id_ok) begin
            st_n = ST_NOT_FOUND;
          end else begin
            // shell rises with the first other high task
            if ((hc_r == '0) && (id_r != '0) && pres_w[0]) begin
              h_n[0] = 1'b1;
              hc_n   = hc_n + CNT_W'(1);
            end
            if (!h_n[id_r]) begin
              h_n  = h_n | id_oh;
              hc_n = hc_n + CNT_W'(1);
            end
          end
        end
        CMD_QUANTUM: begin
          pick_req = 1'b1;
        end
        default: begin
          st_n = ST_REFUSED;
        end
      endcase
    end
  end

  assign dp_st.out_free = !out_valid_r || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= NSLOT'(1);
      high_r      <= '0;
      running_r   <= '0;
      hc_r        <= '0;
      do_pick_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        present_r <= p_n[NSLOT-1:0];
        high_r    <= h_n[NSLOT-1:0];
        hc_r      <= hc_n;
        do_pick_r <= pick_req;
        if (run_clr) running_r <= '0;
      end
      if (ctl.high_pick && do_pick_r) begin
        running_r <= (hc_r != '0) ? high_id : pick_r;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_data.cmd;
      id_r  <= in_data.task_id;
    end
    if (ctl.exec) begin
      status_r <= st_n;
      new_id_r <= nid_n;
      before_r <= running_r;
      from_r   <= from_n;
    end
    if (ctl.next) begin
      pick_r <= next_id;
    end
    if (ctl.out_load) begin
      out_data_r.status     <= status_r;
      out_data_r.running_id <= running_r;
      out_data_r.switched   <= (status_r != ST_EMPTY) && (running_r != before_r);
      out_data_r.new_id     <= new_id_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/two_level_round_robin_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// two_level_round_robin_task_scheduler_unit
// round-robin scheduler over a ring of task slots with low and high priority
// ----------------------------------------------------------------------------
//
//   channel | ports                          | moves
//   --------+--------------------------------+----------------------------------
//   in      | in_valid, in_ready, in_data    | one command (cmd, task_id)
//   out     | out_valid, out_ready, out_data | one result per command
//
// - a command goes from acceptance to its result in the output register
//   through the steps: apply to the slot table, next-present search, high
//   search, result load; the two ring searches sit in stages of their own
// - a new command is taken in the cycle its predecessor's result is loaded,
//   so commands never overlap in the steps above
// - a result that is not taken stalls the sequencer in its last step; the
//   following command is then held off at in_ready
// - rst_n (synchronous) leaves only the shell (slot 0) present, all tasks
//   low, the shell running and no result pending
//
module two_level_round_robin_task_scheduler_unit
  import tlrr_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // command and status signals between sequencer and datapath
  ctl_t       ctl;
  dp_status_t dp_st;

  // sequencer: steps each transaction through the datapath
  tlrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_st    (dp_st),
    .ctl      (ctl)
  );

  // datapath: slot table, ring searches and the result register
  tlrr_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .dp_st     (dp_st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an accepted transaction is applied in the next cycle
  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ctl.exec)
    else $error("accepted command not applied");

  // a pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // the sequencer issues at most one processing step per cycle
  a_one_step : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.exec, ctl.next, ctl.high_pick, ctl.out_load}))
    else $error("overlapping sequencer steps");

  // an empty ring reports slot 0 and no switch
  a_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_EMPTY)) |->
      ((out_data.running_id == '0) && !out_data.switched))
    else $error("empty ring result malformed");

endmodule
